>>> rtl/core/pctbl_pkg.sv
// ----------------------------------------------------------------------------
// pctbl_pkg
// Types, sizes and codes of the per-client token bucket limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package pctbl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam int PERIOD_W = 20;
  localparam int SIZE_W   = 16;
  localparam int CAP_W    = PERIOD_W + SIZE_W;
  localparam int EV_W     = 9;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd200;
  localparam logic [SIZE_W-1:0]   SIZE_RESET   = 16'd600;

  localparam logic [0:0] REG_PERIOD = 1'b0;
  localparam logic [0:0] REG_SIZE   = 1'b1;

  localparam logic [2:0] V_ALLOW_OLD = 3'd0;
  localparam logic [2:0] V_ALLOW_NEW = 3'd1;
  localparam logic [2:0] V_NO_TOKENS = 3'd2;
  localparam logic [2:0] V_FULL      = 3'd3;
  localparam logic [2:0] V_SWEEP     = 3'd4;

  typedef struct packed {
    logic [31:0]       addr;
    logic [SIZE_W-1:0] tokens;
    logic [63:0]       stamp;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/per_client_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// per_client_token_bucket_limiter
// Token bucket table keyed by client address, one bucket per client.
// ----------------------------------------------------------------------------
// Usage: present an item on req_* with req_valid; it is taken when req_stall
// is low. req_type 0 checks client_ip at time now_us, req_type 1 sweeps the
// table. Each item yields one result item on res_valid/limited/verdict/
// evicted_count, held until res_stall is low.
// One item is in work at a time; req_stall is high until the result is
// registered. Buckets live in one 256-entry memory read one entry per cycle.
// A lookup visits each live entry in LK_CHK and LK_CMP and each empty slot in
// LK_CHK alone; the refill of a bucket runs RF_LD, a 16-step serial divider
// in RF_DIV and RF_FIN; a sweep visits each live entry in SW_CHK and the
// refill states and each empty slot in SW_CHK alone. A miss on a full table
// adds a forced sweep before the allocation.
// Reset empties the table (valid flops cleared) and restores the period and
// size registers; no clearing pass runs. A stalled result blocks the next
// result only; a new item may be accepted while it waits.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module per_client_token_bucket_limiter
  import pctbl_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire [0:0]           cfg_index,
  input  wire [PERIOD_W-1:0]  cfg_data,
  input  wire                 req_valid,
  output logic                req_stall,
  input  wire                 req_type,
  input  wire [31:0]          client_ip,
  input  wire [63:0]          now_us,
  output logic                res_valid,
  input  wire                 res_stall,
  output logic                limited,
  output logic [2:0]          verdict,
  output logic [EV_W-1:0]     evicted_count
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LK_CHK = 4'd1;
  localparam logic [3:0] ST_LK_CMP = 4'd2;
  localparam logic [3:0] ST_MISS   = 4'd3;
  localparam logic [3:0] ST_SW_CHK = 4'd4;
  localparam logic [3:0] ST_RF_LD  = 4'd5;
  localparam logic [3:0] ST_RF_DIV = 4'd6;
  localparam logic [3:0] ST_RF_FIN = 4'd7;
  localparam logic [3:0] ST_SW_END = 4'd8;
  localparam logic [3:0] ST_ALLOC  = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  logic [PERIOD_W-1:0] period;
  logic [SIZE_W-1:0]   max_tokens;
  logic [PERIOD_W-1:0] per_eff;
  logic [CAP_W-1:0]    cap;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  logic   rd_en;
  logic   wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data;

  logic [3:0]            state;
  logic [TABLE_DEPTH-1:0] valid;
  logic [CNT_W-1:0]      live;
  logic [IDX_W-1:0]      idx;
  logic                  sweeping;
  logic                  forced;
  logic [31:0]           ip_r;
  logic [63:0]           now_r;
  logic                  free_found;
  logic [IDX_W-1:0]      free_slot;
  logic [EV_W-1:0]       ev;
  logic                  lim_r;
  logic [2:0]            verd_r;

  logic [PERIOD_W-1:0]   rem;
  logic [SIZE_W-1:0]     lo;
  logic [SIZE_W-1:0]     quo;
  logic [3:0]            step;
  logic [SIZE_W-1:0]     tok_r;

  logic [63:0]           diff;
  logic [63:0]           elapsed;
  logic [CAP_W-1:0]      el_clamp;
  logic [PERIOD_W:0]     rem_sh;
  logic                  qbit;
  logic [SIZE_W:0]       tsum;
  logic                  bucket_full;
  logic [SIZE_W-1:0]     tok_new;

  assign per_eff   = (period == '0) ? PERIOD_W'(1) : period;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    diff     = now_r - rd_data.stamp;
    elapsed  = (now_r > rd_data.stamp) ? diff : 64'd0;
    el_clamp = (elapsed > {{(64-CAP_W){1'b0}}, cap}) ? cap : elapsed[CAP_W-1:0];
    rem_sh   = {rem, lo[SIZE_W-1]};
    qbit     = (rem_sh >= {1'b0, per_eff});
    tsum     = {1'b0, tok_r} + {1'b0, quo};
    bucket_full = (tsum >= {1'b0, max_tokens});
    tok_new  = bucket_full ? max_tokens : tsum[SIZE_W-1:0];
  end

  always_comb begin
    rd_en   = (state == ST_LK_CHK || state == ST_SW_CHK) && valid[idx];
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    if (state == ST_RF_FIN) begin
      if (sweeping) begin
        wr_en          = !bucket_full;
        wr_data.tokens = tok_new;
      end else begin
        wr_en = 1'b1;
        if (tok_new == '0) begin
          wr_data.tokens = tok_new;
        end else begin
          wr_data.tokens = tok_new - SIZE_W'(1);
          wr_data.stamp  = now_r;
        end
      end
    end else if (state == ST_ALLOC) begin
      wr_en          = 1'b1;
      wr_addr        = free_slot;
      wr_data.addr   = ip_r;
      wr_data.tokens = (max_tokens == '0) ? '0 : max_tokens - SIZE_W'(1);
      wr_data.stamp  = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    cap <= per_eff * max_tokens;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_RESET;
      max_tokens <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIOD: period     <= cfg_data;
        REG_SIZE:   max_tokens <= cfg_data[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      live       <= '0;
      res_valid  <= 1'b0;
      sweeping   <= 1'b0;
      forced     <= 1'b0;
      free_found <= 1'b0;
      idx        <= '0;
    end else begin
      if (res_valid && !res_stall && state != ST_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            ip_r       <= client_ip;
            now_r      <= now_us;
            ev         <= '0;
            lim_r      <= 1'b0;
            idx        <= '0;
            free_found <= 1'b0;
            forced     <= 1'b0;
            sweeping   <= req_type;
            state      <= req_type ? ST_SW_CHK : ST_LK_CHK;
          end
        end
        ST_LK_CHK: begin
          if (valid[idx]) begin
            state <= ST_LK_CMP;
          end else begin
            if (!free_found) begin
              free_found <= 1'b1;
              free_slot  <= idx;
            end
            if (idx == IDX_LAST) begin
              state <= ST_MISS;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        ST_LK_CMP: begin
          if (rd_data.addr == ip_r) begin
            state <= ST_RF_LD;
          end else if (idx == IDX_LAST) begin
            state <= ST_MISS;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= ST_LK_CHK;
          end
        end
        ST_MISS: begin
          if (live >= CNT_FULL) begin
            sweeping   <= 1'b1;
            forced     <= 1'b1;
            idx        <= '0;
            free_found <= 1'b0;
            state      <= ST_SW_CHK;
          end else begin
            state <= ST_ALLOC;
          end
        end
        ST_SW_CHK: begin
          if (valid[idx]) begin
            state <= ST_RF_LD;
          end else begin
            if (!free_found) begin
              free_found <= 1'b1;
              free_slot  <= idx;
            end
            if (idx == IDX_LAST) begin
              state <= ST_SW_END;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        ST_RF_LD: begin
          rem   <= el_clamp[CAP_W-1:SIZE_W];
          lo    <= el_clamp[SIZE_W-1:0];
          quo   <= '0;
          tok_r <= rd_data.tokens;
          step  <= '0;
          state <= ST_RF_DIV;
        end
        ST_RF_DIV: begin
          rem  <= qbit ? PERIOD_W'(rem_sh - {1'b0, per_eff}) : rem_sh[PERIOD_W-1:0];
          lo   <= {lo[SIZE_W-2:0], 1'b0};
          quo  <= {quo[SIZE_W-2:0], qbit};
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= ST_RF_FIN;
          end
        end
        ST_RF_FIN: begin
          if (sweeping) begin
            if (bucket_full) begin
              valid[idx] <= 1'b0;
              live       <= live - CNT_W'(1);
              ev         <= ev + EV_W'(1);
              if (!free_found) begin
                free_found <= 1'b1;
                free_slot  <= idx;
              end
            end
            if (idx == IDX_LAST) begin
              state <= ST_SW_END;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= ST_SW_CHK;
            end
          end else begin
            lim_r  <= (tok_new == '0);
            verd_r <= (tok_new == '0) ? V_NO_TOKENS : V_ALLOW_OLD;
            state  <= ST_DONE;
          end
        end
        ST_SW_END: begin
          if (!forced) begin
            verd_r <= V_SWEEP;
            state  <= ST_DONE;
          end else if (live >= CNT_FULL) begin
            lim_r  <= 1'b1;
            verd_r <= V_FULL;
            state  <= ST_DONE;
          end else begin
            state <= ST_ALLOC;
          end
        end
        ST_ALLOC: begin
          valid[free_slot] <= 1'b1;
          live             <= live + CNT_W'(1);
          verd_r           <= V_ALLOW_NEW;
          state            <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid     <= 1'b1;
            limited       <= lim_r;
            verdict       <= verd_r;
            evicted_count <= ev;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CNT_FULL) else $error("live count above table depth");

  a_live_match: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(live)) else $error("live count out of step with valid bits");

  a_limited_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && limited |-> (verdict == V_NO_TOKENS || verdict == V_FULL))
    else $error("refusal with a non-refusal verdict");

endmodule

`default_nettype wire

>>> dv/per_client_token_bucket_limiter_checker.sv
// ----------------------------------------------------------------------------
// per_client_token_bucket_limiter_checker
// Watches the request, result and register ports of the limiter, keeps its own
// bucket table, predicts one result per accepted item and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_client_token_bucket_limiter_checker
  import pctbl_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire [0:0]          cfg_index,
  input  wire [PERIOD_W-1:0] cfg_data,
  input  wire                req_valid,
  input  wire                req_stall,
  input  wire                req_type,
  input  wire [31:0]         client_ip,
  input  wire [63:0]         now_us,
  input  wire                res_valid,
  input  wire                res_stall,
  input  wire                limited,
  input  wire [2:0]          verdict,
  input  wire [EV_W-1:0]     evicted_count,
  output int                 outstanding,
  output int                 error_count
);

  typedef struct packed {
    logic            limited;
    logic [2:0]      verdict;
    logic [EV_W-1:0] evicted;
  } decision_t;

  logic [PERIOD_W-1:0] period;
  logic [SIZE_W-1:0]   size;
  logic                bucket_valid  [TABLE_DEPTH];
  logic [31:0]         bucket_addr   [TABLE_DEPTH];
  logic [SIZE_W-1:0]   bucket_tokens [TABLE_DEPTH];
  logic [63:0]         bucket_stamp  [TABLE_DEPTH];
  int                  live_count;
  decision_t           expected_decisions[$];

  function automatic bit refill_bucket(int i, logic [63:0] t);
    logic [63:0] per, sz, elapsed, cap, sum;
    per     = (period == '0) ? 64'd1 : 64'(period);
    sz      = 64'(size);
    elapsed = (t > bucket_stamp[i]) ? t - bucket_stamp[i] : 64'd0;
    cap     = per * sz;
    if (elapsed > cap) elapsed = cap;
    sum = 64'(bucket_tokens[i]) + elapsed / per;
    if (sum >= sz) begin
      bucket_tokens[i] = size;
      return 1'b1;
    end
    bucket_tokens[i] = sum[SIZE_W-1:0];
    return 1'b0;
  endfunction

  function automatic int sweep_table(logic [63:0] t);
    int ev;
    ev = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (bucket_valid[i] && refill_bucket(i, t)) begin
        bucket_valid[i] = 1'b0;
        live_count--;
        ev++;
      end
    end
    return ev;
  endfunction

  function automatic decision_t decide_request(logic kind, logic [31:0] ip,
                                               logic [63:0] t);
    decision_t d;
    int        slot, ev;
    d    = '0;
    ev   = 0;
    slot = -1;
    if (kind) begin
      ev        = sweep_table(t);
      d.verdict = V_SWEEP;
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (bucket_valid[i] && bucket_addr[i] == ip) begin
          slot = i;
          break;
        end
      end
      if (slot >= 0) begin
        void'(refill_bucket(slot, t));
        if (bucket_tokens[slot] == '0) begin
          d.limited = 1'b1;
          d.verdict = V_NO_TOKENS;
        end else begin
          bucket_tokens[slot]--;
          bucket_stamp[slot] = t;
          d.verdict = V_ALLOW_OLD;
        end
      end else begin
        if (live_count >= TABLE_DEPTH) ev = sweep_table(t);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!bucket_valid[i]) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          d.limited = 1'b1;
          d.verdict = V_FULL;
        end else begin
          bucket_valid[slot]  = 1'b1;
          bucket_addr[slot]   = ip;
          bucket_tokens[slot] = (size == '0) ? '0 : size - 1'b1;
          bucket_stamp[slot]  = t;
          live_count++;
          d.verdict = V_ALLOW_NEW;
        end
      end
    end
    d.evicted = ev[EV_W-1:0];
    return d;
  endfunction

  assign outstanding = expected_decisions.size();

  initial error_count = 0;

  always @(posedge clk) begin
    decision_t want;
    if (rst) begin
      period     <= PERIOD_RESET;
      size       <= SIZE_RESET;
      live_count <= 0;
      for (int i = 0; i < TABLE_DEPTH; i++) bucket_valid[i] <= 1'b0;
      expected_decisions.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PERIOD) period <= cfg_data;
        else size <= cfg_data[SIZE_W-1:0];
      end
      if (req_valid && !req_stall)
        expected_decisions.push_back(decide_request(req_type, client_ip, now_us));
      if (res_valid && !res_stall) begin
        if (expected_decisions.size() == 0) begin
          if (error_count < 10)
            $display("%0t: result with nothing expected: limited=%0d verdict=%0d ev=%0d",
                     $realtime, limited, verdict, evicted_count);
          error_count++;
        end else begin
          want = expected_decisions.pop_front();
          if (want.limited !== limited || want.verdict !== verdict ||
              want.evicted !== evicted_count) begin
            if (error_count < 10)
              $display("%0t: mismatch: expected limited=%0d verdict=%0d ev=%0d, got %0d %0d %0d",
                       $realtime, want.limited, want.verdict, want.evicted,
                       limited, verdict, evicted_count);
            error_count++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> dv/per_client_token_bucket_limiter_tb.sv
// ----------------------------------------------------------------------------
// per_client_token_bucket_limiter_tb
// Drives client checks and sweeps into the limiter through a directed part and
// random phases under several register settings and idling patterns, and
// reports the verdict of the checker beside it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_client_token_bucket_limiter_tb;
  import pctbl_pkg::*;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [PERIOD_W-1:0] cfg_data;
  logic                req_valid;
  logic                req_stall;
  logic                req_type;
  logic [31:0]         client_ip;
  logic [63:0]         now_us;
  logic                res_valid;
  logic                res_stall;
  logic                limited;
  logic [2:0]          verdict;
  logic [EV_W-1:0]     evicted_count;
  int                  outstanding;
  int                  error_count;

  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  logic [63:0] clock_us;
  logic [31:0] fresh_ip;

  per_client_token_bucket_limiter u_top (.*);

  per_client_token_bucket_limiter_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("[per_client_token_bucket_limiter] ERROR");
    $finish;
  end

  initial begin
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (3000) @(posedge clk);
      end
      res_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_item(logic kind, logic [31:0] ip, logic [63:0] t);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    client_ip <= ip;
    now_us    <= t;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [PERIOD_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [PERIOD_W-1:0] per, logic [SIZE_W-1:0] sz,
                           int s_pct, int r_pct, int n, int pool,
                           int step_max, bit fill, bit wild);
    logic [31:0] ip;
    logic        kind;
    write_reg(REG_PERIOD, per);
    write_reg(REG_SIZE, {4'h0, sz});
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    for (int k = 0; k < n; k++) begin
      kind = ($urandom_range(99) < 8);
      if (fill && $urandom_range(3) != 0) begin
        ip = fresh_ip;
        fresh_ip++;
      end else if ($urandom_range(9) == 0) begin
        ip = $urandom;
      end else begin
        ip = 32'h0A00_0000 + $urandom_range(pool - 1);
      end
      case ($urandom_range(19))
        0: if (wild) clock_us = {$urandom, $urandom};
        1: clock_us -= $urandom_range(5000);
        default: clock_us += $urandom_range(step_max);
      endcase
      send_item(kind, ip, clock_us);
      if (k == n / 2 && s_pct == 0 && r_pct == 0) begin
        hold_req = 1'b1;
      end
      if (k == n / 3) drain_results();
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_PERIOD;
    cfg_data       = '0;
    req_valid      = 1'b0;
    req_type       = 1'b0;
    client_ip      = '0;
    now_us         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    clock_us       = 64'd1000;
    fresh_ip       = 32'hC0A8_0000;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(1'b0, 32'h0102_0304, 64'd0);
    send_item(1'b1, 32'h0, 64'd10);
    write_reg(REG_PERIOD, 20'd5);
    write_reg(REG_SIZE, 20'd2);
    send_item(1'b0, 32'h0000_0000, 64'd0);
    send_item(1'b0, 32'h0000_0000, 64'd0);
    send_item(1'b0, 32'h0000_0000, 64'd0);
    send_item(1'b0, 32'h0000_0000, 64'd3);
    send_item(1'b0, 32'h0000_0000, 64'd2);
    send_item(1'b0, 32'h0000_0000, 64'd100);
    send_item(1'b0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(1'b0, 32'hFFFF_FFFF, 64'd0);
    send_item(1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(1'b1, 32'h0, 64'd0);
    send_item(1'b0, 32'h5555_AAAA, 64'h5555_5555_AAAA_AAAA);
    send_item(1'b0, 32'hAAAA_5555, 64'hAAAA_AAAA_5555_5555);
    send_item(1'b0, 32'h5555_AAAA, 64'hAAAA_AAAA_5555_5555);
    write_reg(REG_PERIOD, 20'd0);
    write_reg(REG_SIZE, 20'd0);
    send_item(1'b0, 32'h1234_5678, 64'd50);
    send_item(1'b0, 32'h1234_5678, 64'd900);
    send_item(1'b0, 32'h5555_AAAA, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(1'b1, 32'h0, 64'd1000);

    run_phase(PERIOD_RESET, SIZE_RESET, 0, 0, 130, 16, 400, 1'b0, 1'b1);
    run_phase(20'd1, 16'd1, 82, 0, 130, 16, 4, 1'b0, 1'b1);
    run_phase(20'd0, 16'd0, 0, 82, 100, 16, 10, 1'b0, 1'b1);
    run_phase(20'hFFFFF, 16'hFFFF, 22, 22, 330, 16, 50, 1'b1, 1'b0);
    run_phase(20'd5, 16'd3, 0, 0, 130, 64, 30, 1'b0, 1'b1);
    run_phase(20'd1000, 16'hFFFF, 82, 0, 120, 300, 2000, 1'b0, 1'b0);
    run_phase(20'hFFFFF, 16'd1, 0, 82, 100, 32, 3_000_000, 1'b0, 1'b1);
    run_phase(20'd3, 16'd7, 22, 22, 110, 8, 25, 1'b0, 1'b1);

    drain_results();
    repeat (6000) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("[per_client_token_bucket_limiter] OK");
    end else begin
      $display("[per_client_token_bucket_limiter] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/pctbl_pkg.sv
rtl/core/per_client_token_bucket_limiter.sv
dv/per_client_token_bucket_limiter_checker.sv
dv/per_client_token_bucket_limiter_tb.sv
